// File: rtl/sdmc_pkg.sv
// Shared types, constants and magic word tables for the SLIP deframer.
package sdmc_pkg;

  localparam int unsigned LenW = 12;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW = $clog2(QDepth);

  localparam logic [7:0] FrameEnd = 8'hC0;
  localparam logic [7:0] FrameEsc = 8'hDB;
  localparam logic [7:0] FrameEscEnd = 8'hDC;
  localparam logic [7:0] FrameEscEsc = 8'hDD;

  localparam logic [LenW-1:0] MaxLenReset = 12'd1564;
  localparam logic [LenW-1:0] ModemWordLen = 12'd10;
  localparam logic [LenW-1:0] SlipWordLen = 12'd9;

  typedef enum logic {
    KIND_DATA   = 1'b0,
    KIND_REPORT = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_PACKET  = 2'd0,
    STATUS_MODEM   = 2'd1,
    STATUS_SLIP    = 2'd2,
    STATUS_OVERRUN = 2'd3
  } status_e;

  typedef struct packed {
    kind_e           kind;
    logic [7:0]      data;
    status_e         status;
    logic [LenW-1:0] len;
  } result_t;

  // "MODE=MODEM"
  function automatic logic [7:0] modem_char(logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0, 4'd5: ch = 8'h4D;
      4'd1, 4'd6: ch = 8'h4F;
      4'd2, 4'd7: ch = 8'h44;
      4'd3, 4'd8: ch = 8'h45;
      4'd4:       ch = 8'h3D;
      4'd9:       ch = 8'h4D;
      default:    ch = 8'h00;
    endcase
    return ch;
  endfunction

  // "MODE=SLIP"
  function automatic logic [7:0] slip_char(logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = 8'h4D;
      4'd1:    ch = 8'h4F;
      4'd2:    ch = 8'h44;
      4'd3:    ch = 8'h45;
      4'd4:    ch = 8'h3D;
      4'd5:    ch = 8'h53;
      4'd6:    ch = 8'h4C;
      4'd7:    ch = 8'h49;
      4'd8:    ch = 8'h50;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// File: rtl/sdmc_front.sv
// Front end: SLIP unescaping, frame length tracking and magic word classification.
module sdmc_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      beat_i,
  input  logic [7:0]                rx_byte_i,
  input  logic                      cfg_we_i,
  input  logic [sdmc_pkg::LenW-1:0] cfg_data_i,
  output logic                      res_valid_o,
  output sdmc_pkg::result_t         res_o
);
  import sdmc_pkg::*;

  logic            esc_q, esc_d;
  logic [LenW-1:0] len_q, len_d;
  logic            modem_q, modem_d;
  logic            slip_q, slip_d;
  logic [LenW-1:0] max_q;

  logic [7:0] dec_byte;
  logic       do_keep;
  logic       do_close;

  always_comb begin
    dec_byte = rx_byte_i;
    if (esc_q) begin
      if (rx_byte_i == FrameEscEnd) dec_byte = FrameEnd;
      else if (rx_byte_i == FrameEscEsc) dec_byte = FrameEsc;
    end
  end

  assign do_keep  = esc_q || (rx_byte_i != FrameEsc && rx_byte_i != FrameEnd);
  assign do_close = !esc_q && rx_byte_i == FrameEnd;

  always_comb begin
    esc_d       = esc_q;
    len_d       = len_q;
    modem_d     = modem_q;
    slip_d      = slip_q;
    res_valid_o = 1'b0;
    res_o       = '{kind: KIND_DATA, data: 8'h00, status: STATUS_PACKET, len: '0};
    if (beat_i) begin
      if (do_keep) begin
        esc_d = 1'b0;
        if (len_q < max_q) begin
          modem_d = modem_q && len_q < ModemWordLen && modem_char(len_q[3:0]) == dec_byte;
          slip_d  = slip_q && len_q < SlipWordLen && slip_char(len_q[3:0]) == dec_byte;
          len_d   = len_q + 1'b1;
          res_valid_o = 1'b1;
          res_o.data  = dec_byte;
        end
      end else if (do_close) begin
        esc_d   = 1'b0;
        len_d   = '0;
        modem_d = 1'b1;
        slip_d  = 1'b1;
        if (len_q != '0) begin
          res_valid_o = 1'b1;
          res_o.kind  = KIND_REPORT;
          res_o.len   = len_q;
          if (len_q >= max_q) res_o.status = STATUS_OVERRUN;
          else if (modem_q && len_q == ModemWordLen) res_o.status = STATUS_MODEM;
          else if (slip_q && len_q == SlipWordLen) res_o.status = STATUS_SLIP;
        end
      end else begin
        esc_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q   <= 1'b0;
      len_q   <= '0;
      modem_q <= 1'b1;
      slip_q  <= 1'b1;
      max_q   <= MaxLenReset;
    end else begin
      esc_q   <= esc_d;
      len_q   <= len_d;
      modem_q <= modem_d;
      slip_q  <= slip_d;
      if (cfg_we_i) max_q <= cfg_data_i;
    end
  end

endmodule

// File: rtl/sdmc_queue.sv
// Result queue between the front end and the result port.
module sdmc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  sdmc_pkg::result_t wr_data_i,
  output logic              full_o,
  input  logic              rd_i,
  output logic              empty_o,
  output sdmc_pkg::result_t rd_data_o
);
  import sdmc_pkg::*;

  result_t           mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]    cnt_q;
  logic              do_wr, do_rd;

  assign full_o    = cnt_q == (QPtrW+1)'(QDepth);
  assign empty_o   = cnt_q == '0;
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_rd) rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
      else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// File: rtl/slip_deframer_magic_classifier.sv
// Top level of the SLIP receive deframer with magic frame classification.
//
// Input side is a queue write port: rx_byte_i is taken on a clock edge with
// push high and full low. Each raw byte yields at most one result: a decoded
// data byte, or at a closing 0xC0 an end of frame report with length and
// status (packet, MODE=MODEM, MODE=SLIP, overrun). Escape bytes, bytes past
// capacity and empty frames give nothing.
// Result side is a queue read port: the oldest result sits on the result
// ports while empty is low and leaves on an edge with pop high.
// A result is queued on the edge that takes its input beat. Throughput is one
// byte per cycle while full is low, set by the front end, which updates its
// state on each accepted byte; a four entry result queue decouples the two
// sides, and full rises only when it holds four results not yet popped.
// The capacity register is written through cfg_valid_i/cfg_data_i, always
// ready, and should only be changed while the block is idle.
// Reset (rst_ni low, asynchronous) empties the queue, closes any open frame
// and loads the capacity of 1564.
module slip_deframer_magic_classifier (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [7:0]                rx_byte_i,
  output logic                      empty,
  input  logic                      pop,
  output logic                      result_kind_o,
  output logic [7:0]                data_byte_o,
  output logic [1:0]                frame_status_o,
  output logic [sdmc_pkg::LenW-1:0] frame_len_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [sdmc_pkg::LenW-1:0] cfg_data_i
);
  import sdmc_pkg::*;

  logic    in_beat;
  logic    res_valid;
  result_t res;
  result_t head;

  assign in_beat     = push && !full;
  assign cfg_ready_o = 1'b1;

  sdmc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (in_beat),
    .rx_byte_i   (rx_byte_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sdmc_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (res_valid),
    .wr_data_i (res),
    .full_o    (full),
    .rd_i      (pop),
    .empty_o   (empty),
    .rd_data_o (head)
  );

  assign result_kind_o  = head.kind;
  assign data_byte_o    = head.data;
  assign frame_status_o = head.status;
  assign frame_len_o    = head.len;

endmodule
